// ===== rtl/sbpr_pkg.sv =====
// shared types and constants for the six-button pad responder
// no dependencies; imported by every module of the block
`default_nettype none

package sbpr_pkg;

	// field widths
	localparam int unsigned BTN_W    = 12;
	localparam int unsigned NIB_W    = 4;
	localparam int unsigned CNT_W    = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 1;

	// button bit positions in the button word
	localparam int unsigned BTN_UP         = 0;
	localparam int unsigned BTN_DOWN       = 1;
	localparam int unsigned BTN_LEFT       = 2;
	localparam int unsigned BTN_RIGHT      = 3;
	localparam int unsigned BTN_SHORT      = 4;
	localparam int unsigned BTN_START      = 5;
	localparam int unsigned BTN_FORWARD    = 6;
	localparam int unsigned BTN_ROUNDHOUSE = 7;
	localparam int unsigned BTN_JAB        = 8;
	localparam int unsigned BTN_STRONG     = 9;
	localparam int unsigned BTN_FIERCE     = 10;
	localparam int unsigned BTN_SELECT     = 11;

	// constants
	localparam logic [NIB_W-1:0] NIB_ALL_HIGH  = 4'hF;
	localparam logic [CNT_W-1:0] CNT_MAX       = 16'hFFFF;
	localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd512;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THREE_BUTTON = 1'b0,
		CFG_TIMEOUT      = 1'b1
	} cfg_idx_t;

	// configuration register contents
	typedef struct packed {
		logic             three_button_mode;
		logic [CNT_W-1:0] timeout_ticks;
	} cfg_t;

	// position in the select pulse train, one-hot
	typedef enum logic [8:0] {
		PH_INIT   = 9'b000000001,
		PH_TOP    = 9'b000000010,
		PH_VALLEY = 9'b000000100,
		PH_FALL2  = 9'b000001000,
		PH_RISE3  = 9'b000010000,
		PH_FALL3  = 9'b000100000,
		PH_RISE4  = 9'b001000000,
		PH_FALL4  = 9'b010000000,
		PH_RISE5  = 9'b100000000
	} phase_t;

endpackage : sbpr_pkg

`default_nettype wire

// ===== rtl/six_button_pad_responder.sv =====
// top level of the six-button pad responder: input register and output handshake
// depends on sbpr_pkg, sbpr_cfg_regs, sbpr_phase_engine
`default_nettype none

// Pad side of a select-multiplexed six-button controller. Each item is one
// timer tick carrying the select level and the 12-bit button word; each item
// gives exactly one result: the data nibble and up/down levels after that tick.
// Items flow one per clock while the output is not stalled: a tick is held in the
// input register, then the phase sequencer updates its state and driven-line
// registers, which are the result held for the output. in_stall rises only
// while both the input register and the result are full and the output is
// stalled.

module six_button_pad_responder
	import sbpr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// tick input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 select_level,
	input  wire logic [BTN_W-1:0]     buttons,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [NIB_W-1:0]     data_nibble,
	output logic                      up_line,
	output logic                      down_line
);

	cfg_t             cfg;
	logic             valid_s1;
	logic             sel_s1;
	logic [BTN_W-1:0] btn_s1;
	logic             out_valid_q;
	logic             res_free;
	logic             advance;

	// configuration registers
	sbpr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// flow control
	assign res_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && res_free;
	assign in_stall = valid_s1 && !res_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sel_s1 <= select_level;
			btn_s1 <= buttons;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= valid_s1;
		end
	end

	assign out_valid = out_valid_q;

	// sequencer; its line registers are the held result
	sbpr_phase_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.sel         (sel_s1),
		.btn         (btn_s1),
		.cfg         (cfg),
		.data_nibble (data_nibble),
		.up_line     (up_line),
		.down_line   (down_line)
	);

`ifndef SYNTH
	// input stalls only behind a full, stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	// a processed item always shows up as a result
	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item produced no result");

	// a stalled result holds its lines
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=>
		out_valid_q && $stable({data_nibble, up_line, down_line}))
		else $error("stalled result changed");
`endif

endmodule : six_button_pad_responder

`default_nettype wire

// ===== rtl/sbpr_cfg_regs.sv =====
// configuration registers of the pad responder
// depends on sbpr_pkg
`default_nettype none

module sbpr_cfg_regs
	import sbpr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.three_button_mode <= 1'b0;
			cfg_q.timeout_ticks     <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_THREE_BUTTON: cfg_q.three_button_mode <= cfg_data[0];
				CFG_TIMEOUT:      cfg_q.timeout_ticks     <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule : sbpr_cfg_regs

`default_nettype wire

// ===== rtl/sbpr_phase_engine.sv =====
// phase sequencer, tick counter and driven line registers
// depends on sbpr_pkg
`default_nettype none

module sbpr_phase_engine
	import sbpr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             sel,
	input  wire logic [BTN_W-1:0] btn,
	input  cfg_t                  cfg,
	output logic      [NIB_W-1:0] data_nibble,
	output logic                  up_line,
	output logic                  down_line
);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [NIB_W-1:0] nibble_q, nibble_d;
	logic             up_q, up_d, down_q, down_d;
	logic [NIB_W-1:0] nib_mid, nib_low, nib_six;
	logic             late;

	// nibbles built from the button word
	assign nib_mid = {btn[BTN_LEFT], btn[BTN_RIGHT], btn[BTN_FORWARD], btn[BTN_ROUNDHOUSE]};
	assign nib_low = {2'b00, btn[BTN_SHORT], btn[BTN_START]};
	assign nib_six = {btn[BTN_JAB], btn[BTN_SELECT], btn[BTN_STRONG], btn[BTN_FORWARD]};

	// saturating tick count and timeout check
	assign elapsed_inc = (elapsed_q == CNT_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign late        = (elapsed_inc >= cfg.timeout_ticks);

	// next phase and driven levels
	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_inc;
		nibble_d  = nibble_q;
		up_d      = up_q;
		down_d    = down_q;
		case (phase_q)
			PH_TOP: begin
				if (!sel) begin
					nibble_d = nib_low;
					up_d     = btn[BTN_UP];
					down_d   = btn[BTN_DOWN];
					phase_d  = PH_VALLEY;
				end
			end
			PH_VALLEY: begin
				if (sel) begin
					nibble_d  = nib_mid;
					up_d      = btn[BTN_UP];
					down_d    = btn[BTN_DOWN];
					elapsed_d = '0;
					phase_d   = PH_FALL2;
				end
			end
			PH_FALL2: begin
				if (!sel) begin
					nibble_d = nib_low;
					up_d     = btn[BTN_UP];
					down_d   = btn[BTN_DOWN];
					phase_d  = (late || cfg.three_button_mode) ? PH_VALLEY : PH_RISE3;
				end
			end
			PH_RISE3: begin
				if (sel) begin
					nibble_d  = nib_mid;
					up_d      = btn[BTN_UP];
					down_d    = btn[BTN_DOWN];
					elapsed_d = '0;
					phase_d   = PH_FALL3;
				end
			end
			PH_FALL3: begin
				if (!sel) begin
					nibble_d = nib_low;
					up_d     = 1'b0;
					down_d   = 1'b0;
					phase_d  = late ? PH_VALLEY : PH_RISE4;
				end
			end
			PH_RISE4: begin
				if (sel) begin
					nibble_d  = nib_six;
					up_d      = btn[BTN_FIERCE];
					down_d    = btn[BTN_STRONG];
					elapsed_d = '0;
					phase_d   = PH_FALL4;
				end
			end
			PH_FALL4: begin
				if (!sel) begin
					nibble_d = nib_low | 4'b1100;
					up_d     = 1'b1;
					down_d   = 1'b1;
					phase_d  = late ? PH_VALLEY : PH_RISE5;
				end
			end
			PH_RISE5: begin
				if (sel) begin
					nibble_d = nib_mid;
					up_d     = btn[BTN_UP];
					down_d   = btn[BTN_DOWN];
					phase_d  = PH_TOP;
				end
			end
			default: begin
				// init and any stray code: wait for select high
				if (sel) begin
					nibble_d = NIB_ALL_HIGH;
					phase_d  = PH_TOP;
				end
			end
		endcase
	end

	// state registers, updated once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_INIT;
			elapsed_q <= '0;
			nibble_q  <= '0;
			up_q      <= 1'b0;
			down_q    <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			nibble_q  <= nibble_d;
			up_q      <= up_d;
			down_q    <= down_d;
		end
	end

	assign data_nibble = nibble_q;
	assign up_line     = up_q;
	assign down_line   = down_q;

`ifndef SYNTH
	// third fall releases both direction lines
	a_fall3_lines_low: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_FALL3 && !sel |=> !up_q && !down_q)
		else $error("direction lines not released on third fall");

	// a timed rise clears the tick count
	a_rise_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && sel && (phase_q == PH_VALLEY || phase_q == PH_RISE3 ||
		phase_q == PH_RISE4) |=> elapsed_q == '0)
		else $error("tick count not cleared on timed rise");

	// three-button mode never leaves the first two pulses
	a_three_button_loop: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cfg.three_button_mode && phase_q == PH_FALL2 && !sel
		|=> phase_q == PH_VALLEY)
		else $error("three-button mode went past the second pulse");
`endif

endmodule : sbpr_phase_engine

`default_nettype wire

// ===== test/tb_six_button_pad_responder.sv =====
// testbench for six_button_pad_responder: random select pulse trains and button words,
// with results checked against a line predictor kept in a small scoreboard class
// depends on sbpr_pkg and the six_button_pad_responder rtl
`default_nettype none

module tb_six_button_pad_responder;
	import sbpr_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int SOAK_TICKS      = 40;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int IDLE_PERCENT    = 12;

	// levels driven on the pad lines after one tick
	typedef struct {
		logic [NIB_W-1:0] nibble;
		logic             up;
		logic             down;
	} pad_lines_t;

	// one stretch of random ticks under one register setting
	typedef struct {
		bit               tbm;
		logic [CNT_W-1:0] tmo;
		int               n_ticks;
		int               max_hold;
		bit               quiet;
		bit               squeeze;
	} plan_t;

	// predicts the pad lines for every accepted tick and checks the results in order
	class line_scoreboard;
		bit               three_btn;
		logic [CNT_W-1:0] tmo;
		phase_t           ph;
		logic [CNT_W-1:0] ticks;
		logic [NIB_W-1:0] nib_q;
		logic             up_q;
		logic             down_q;
		pad_lines_t       due_lines[$];
		int               bad_lines;

		function new();
			three_btn = 1'b0;
			tmo = TIMEOUT_RESET;
			ph = PH_INIT;
			ticks = '0;
			nib_q = '0;
			up_q = 1'b0;
			down_q = 1'b0;
			bad_lines = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_THREE_BUTTON: three_btn = val[0];
				CFG_TIMEOUT:      tmo = val;
				default:          ;
			endcase
		endfunction

		function bit late();
			return ticks >= tmo;
		endfunction

		function bit after_timed_rise();
			return ph == PH_FALL2 || ph == PH_FALL3 || ph == PH_FALL4;
		endfunction

		function int pending();
			return due_lines.size();
		endfunction

		function void drive(logic [NIB_W-1:0] n, logic u, logic d);
			nib_q = n;
			up_q = u;
			down_q = d;
		endfunction

		// advance the pulse train position by one accepted tick
		function void note_tick(logic sel, logic [BTN_W-1:0] b);
			logic [NIB_W-1:0] mid;
			logic [NIB_W-1:0] low;
			mid = {b[BTN_LEFT], b[BTN_RIGHT], b[BTN_FORWARD], b[BTN_ROUNDHOUSE]};
			low = {2'b00, b[BTN_SHORT], b[BTN_START]};
			if (ticks != CNT_MAX)
				ticks++;
			case (ph)
				PH_TOP: if (!sel) begin
					drive(low, b[BTN_UP], b[BTN_DOWN]);
					ph = PH_VALLEY;
				end
				PH_VALLEY: if (sel) begin
					drive(mid, b[BTN_UP], b[BTN_DOWN]);
					ticks = '0;
					ph = PH_FALL2;
				end
				PH_FALL2: if (!sel) begin
					drive(low, b[BTN_UP], b[BTN_DOWN]);
					ph = (late() || three_btn) ? PH_VALLEY : PH_RISE3;
				end
				PH_RISE3: if (sel) begin
					drive(mid, b[BTN_UP], b[BTN_DOWN]);
					ticks = '0;
					ph = PH_FALL3;
				end
				PH_FALL3: if (!sel) begin
					drive(low, 1'b0, 1'b0);
					ph = late() ? PH_VALLEY : PH_RISE4;
				end
				PH_RISE4: if (sel) begin
					drive({b[BTN_JAB], b[BTN_SELECT], b[BTN_STRONG], b[BTN_FORWARD]},
						b[BTN_FIERCE], b[BTN_STRONG]);
					ticks = '0;
					ph = PH_FALL4;
				end
				PH_FALL4: if (!sel) begin
					drive(low | 4'hC, 1'b1, 1'b1);
					ph = late() ? PH_VALLEY : PH_RISE5;
				end
				PH_RISE5: if (sel) begin
					drive(mid, b[BTN_UP], b[BTN_DOWN]);
					ph = PH_TOP;
				end
				// init: all data lines high on the first rise, up/down kept
				default: if (sel) begin
					nib_q = NIB_ALL_HIGH;
					ph = PH_TOP;
				end
			endcase
			due_lines.push_back('{nib_q, up_q, down_q});
		endfunction

		// compare one result with the oldest prediction
		function void check_lines(logic [NIB_W-1:0] nib, logic up, logic down);
			pad_lines_t want;
			if (due_lines.size() == 0) begin
				bad_lines++;
				if (bad_lines <= 10)
					$display("unexpected result: nibble %h up %b down %b", nib, up, down);
				return;
			end
			want = due_lines.pop_front();
			if (nib !== want.nibble || up !== want.up || down !== want.down) begin
				bad_lines++;
				if (bad_lines <= 10)
					$display("line mismatch: expected nibble %h up %b down %b, got %h %b %b",
						want.nibble, want.up, want.down, nib, up, down);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_THREE_BUTTON;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 select_level = 1'b0;
	logic [BTN_W-1:0]     buttons = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [NIB_W-1:0]     data_nibble;
	logic                 up_line;
	logic                 down_line;

	line_scoreboard lines;
	logic           cur_sel = 1'b0;
	bit             no_idle = 1'b0;
	bit             hold_off_req = 1'b0;
	int             cycles = 0;

	// directed ticks: bit 12 is the select level, bits 11..0 the button word
	logic [12:0] directed[22] = '{
		13'h0FFF, 13'h1000, 13'h1FFF, 13'h0FFF, 13'h1FFF, 13'h0000,
		13'h1000, 13'h0FFF, 13'h1FFF, 13'h0000, 13'h1FFF, 13'h0555,
		13'h1AAA, 13'h0AAA, 13'h1555, 13'h0555, 13'h1AAA, 13'h0AAA,
		13'h1555, 13'h1FFF, 13'h0000, 13'h0FFF
	};

	// mode, timeout, ticks, longest hold, no idling, long receiver hold-off
	plan_t plans[9] = '{
		'{1'b0, 16'hFFFF, 200, 6,  1'b1, 1'b0},
		'{1'b1, 16'd512,  150, 6,  1'b0, 1'b0},
		'{1'b0, 16'd1,    150, 4,  1'b0, 1'b0},
		'{1'b0, 16'd8,    250, 10, 1'b0, 1'b0},
		'{1'b1, 16'd3,    150, 5,  1'b0, 1'b0},
		'{1'b0, 16'd0,    100, 4,  1'b0, 1'b0},
		'{1'b0, 16'd20,   300, 30, 1'b0, 1'b1},
		'{1'b1, 16'hFFFF, 150, 8,  1'b0, 1'b0},
		'{1'b0, 16'd512,  200, 8,  1'b0, 1'b0}
	};

	six_button_pad_responder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.select_level (select_level),
		.buttons      (buttons),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_nibble  (data_nibble),
		.up_line      (up_line),
		.down_line    (down_line)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL six_button_pad_responder");
		$finish;
	end

	// result side: check accepted results, stall at random or for a long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				lines.check_lines(data_nibble, up_line, down_line);
			if (hold_off_req && hold_left == 0) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	function automatic logic [BTN_W-1:0] rand_buttons();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return BTN_W'($urandom_range(4095));
		endcase
	endfunction

	// offer one tick, with an occasional gap before it, and wait until it is taken
	task automatic send_tick(logic sel, logic [BTN_W-1:0] b);
		if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		select_level <= sel;
		buttons <= b;
		do @(posedge clk); while (in_stall);
		lines.note_tick(sel, b);
	endtask

	// wait until every predicted result has been seen
	task automatic drain();
		while (lines.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_config(bit tbm, logic [CNT_W-1:0] tmo);
		cfg_we <= 1'b1;
		cfg_index <= CFG_THREE_BUTTON;
		cfg_data <= {{(CFG_W-1){1'b0}}, tbm};
		@(posedge clk);
		lines.set_reg(CFG_THREE_BUTTON, {{(CFG_W-1){1'b0}}, tbm});
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= tmo;
		@(posedge clk);
		lines.set_reg(CFG_TIMEOUT, tmo);
		cfg_we <= 1'b0;
	endtask

	// select pulse train with random hold lengths, some long holds and one-tick glitches
	task automatic run_pulse_train(int n_ticks, int max_hold);
		int sent;
		int hold;
		sent = 0;
		while (sent < n_ticks) begin
			cur_sel = ~cur_sel;
			hold = $urandom_range(max_hold, 1);
			if ($urandom_range(99) < 10)
				hold += $urandom_range(3 * max_hold, 1);
			repeat (hold) begin
				if ($urandom_range(99) < 5)
					send_tick(~cur_sel, rand_buttons());
				else
					send_tick(cur_sel, rand_buttons());
				sent++;
			end
		end
	endtask

	// main sequence
	initial begin
		lines = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk through both six-button cycles at reset settings
		foreach (directed[k]) begin
			cur_sel = directed[k][12];
			send_tick(directed[k][12], directed[k][11:0]);
		end
		in_valid <= 1'b0;
		drain();

		// random pulse trains under each register setting
		foreach (plans[k]) begin
			no_idle = plans[k].quiet;
			write_config(plans[k].tbm, plans[k].tmo);
			hold_off_req = plans[k].squeeze;
			run_pulse_train(plans[k].n_ticks, plans[k].max_hold);
			in_valid <= 1'b0;
			drain();
		end

		// late fall: a timed rise, then select held high past the timeout
		no_idle = 1'b1;
		write_config(1'b0, 16'd30);
		do begin
			cur_sel = ~cur_sel;
			send_tick(cur_sel, rand_buttons());
		end while (!lines.after_timed_rise());
		repeat (SOAK_TICKS) send_tick(1'b1, rand_buttons());
		send_tick(1'b0, rand_buttons());
		send_tick(1'b1, rand_buttons());
		send_tick(1'b0, rand_buttons());
		in_valid <= 1'b0;
		drain();
		repeat (4) @(posedge clk);

		if (lines.bad_lines == 0 && lines.pending() == 0)
			$display("PASS six_button_pad_responder");
		else
			$display("FAIL six_button_pad_responder");
		$finish;
	end

endmodule

`default_nettype wire
